// File: hdl/kmf_pkg.sv
// Shared types and constants of the Kerr metric function evaluator.
// Holds the beat payload structs, the cell payload structs and the CORDIC angle table.
// No dependencies.
`default_nettype none
package kmf_pkg;

	localparam int RADIUS_W = 24;
	localparam int ANGLE_W  = 16;
	localparam int MASS_W   = 24;
	localparam int SPIN_W   = 25;
	localparam int SIGMA_W  = 48;
	localparam int DELTA_W  = 48;
	localparam int AREA_W   = 60;
	localparam int ERGO_W   = 32;
	localparam int CFG_W    = 25;

	// CORDIC datapath: x and y in Q2.30 with headroom, angles where pi = 2^31
	localparam int XY_W      = 34;
	localparam int Z_W       = 32;
	localparam int TABLE_LEN = 24;
	localparam logic signed [XY_W-1:0] CORDIC_X0 = 34'sh026DD3B6A;

	// Square root: 48-bit radicand, one result bit per step
	localparam int RADICAND_W = 48;
	localparam int SQRT_STEPS = 24;
	localparam int REM_W      = 27;

	typedef enum logic [0:0] {
		REG_MASS = 1'b0,
		REG_SPIN = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [RADIUS_W-1:0] radius;
		logic [ANGLE_W-1:0]  polar_angle;
	} item_t;

	typedef struct packed {
		logic [SIGMA_W-1:0]        sigma_value;
		logic signed [DELTA_W-1:0] delta_value;
		logic [AREA_W-1:0]         area_value;
		logic [ERGO_W-1:0]         ergosphere_radius;
	} result_t;

	typedef struct packed {
		logic signed [XY_W-1:0] x;
		logic signed [XY_W-1:0] y;
		logic signed [Z_W-1:0]  z;
		logic [RADIUS_W-1:0]    radius;
	} cordic_t;

	typedef struct packed {
		logic [RADICAND_W-1:0] rest;
		logic [REM_W-1:0]      rem;
		logic [SQRT_STEPS-1:0] root;
		logic [SIGMA_W-1:0]    sigma;
		logic [DELTA_W-1:0]    delta;
		logic [AREA_W-1:0]     area;
	} sqrt_t;

	function automatic logic [Z_W-1:0] atan_entry(input int idx);
		logic [Z_W-1:0] v;
		case (idx)
			0:  v = 32'h20000000;
			1:  v = 32'h12E4051E;
			2:  v = 32'h09FB385B;
			3:  v = 32'h051111D4;
			4:  v = 32'h028B0D43;
			5:  v = 32'h0145D7E1;
			6:  v = 32'h00A2F61E;
			7:  v = 32'h00517C55;
			8:  v = 32'h0028BE53;
			9:  v = 32'h00145F2F;
			10: v = 32'h000A2F98;
			11: v = 32'h000517CC;
			12: v = 32'h00028BE6;
			13: v = 32'h000145F3;
			14: v = 32'h0000A2FA;
			15: v = 32'h0000517D;
			16: v = 32'h000028BE;
			17: v = 32'h0000145F;
			18: v = 32'h00000A30;
			19: v = 32'h00000518;
			20: v = 32'h0000028C;
			21: v = 32'h00000146;
			22: v = 32'h000000A3;
			23: v = 32'h00000051;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

// File: hdl/kmf_cordic_cell.sv
// One CORDIC rotation cell: a fixed shift and angle, registered output.
// Depends on kmf_pkg.
`default_nettype none
module kmf_cordic_cell #(
	parameter int STAGE = 0
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             en,
	input  wire logic             in_vld,
	input  wire kmf_pkg::cordic_t in_pl,
	output logic                  out_vld,
	output kmf_pkg::cordic_t      out_pl
);

	localparam logic signed [kmf_pkg::Z_W-1:0] ANGLE = signed'(kmf_pkg::atan_entry(STAGE));

	kmf_pkg::cordic_t nxt;
	logic signed [kmf_pkg::XY_W-1:0] xs;
	logic signed [kmf_pkg::XY_W-1:0] ys;

	always_comb begin
		xs = in_pl.x >>> STAGE;
		ys = in_pl.y >>> STAGE;
		nxt.radius = in_pl.radius;
		if (in_pl.z >= 0) begin
			nxt.x = in_pl.x - ys;
			nxt.y = in_pl.y + xs;
			nxt.z = in_pl.z - ANGLE;
		end else begin
			nxt.x = in_pl.x + ys;
			nxt.y = in_pl.y - xs;
			nxt.z = in_pl.z + ANGLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else if (en) begin
			out_vld <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_pl <= nxt;
		end
	end

endmodule
`default_nettype wire

// File: hdl/kmf_sqrt_cell.sv
// One restoring square-root cell: settles one root bit, carries finished results along.
// Depends on kmf_pkg.
`default_nettype none
module kmf_sqrt_cell (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire logic           in_vld,
	input  wire kmf_pkg::sqrt_t in_pl,
	output logic                out_vld,
	output kmf_pkg::sqrt_t      out_pl
);

	kmf_pkg::sqrt_t nxt;
	logic [kmf_pkg::REM_W-1:0] rem_sh;
	logic [kmf_pkg::REM_W-1:0] trial;

	always_comb begin
		nxt = in_pl;
		rem_sh = {in_pl.rem[kmf_pkg::REM_W-3:0],
			in_pl.rest[kmf_pkg::RADICAND_W-1 -: 2]};
		trial = {1'b0, in_pl.root, 2'b01};
		nxt.rest = {in_pl.rest[kmf_pkg::RADICAND_W-3:0], 2'b00};
		if (rem_sh >= trial) begin
			nxt.rem = rem_sh - trial;
			nxt.root = {in_pl.root[kmf_pkg::SQRT_STEPS-2:0], 1'b1};
		end else begin
			nxt.rem = rem_sh;
			nxt.root = {in_pl.root[kmf_pkg::SQRT_STEPS-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else if (en) begin
			out_vld <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_pl <= nxt;
		end
	end

endmodule
`default_nettype wire

// File: hdl/kerr_metric_function_eval.sv
// Top level of the Kerr metric function evaluator (Sigma, Delta, A, ergosphere radius).
// Depends on kmf_pkg, kmf_cordic_cell and kmf_sqrt_cell.
//
//   port group   dir  handshake            beat
//   item_*       in   item_valid/stall     radius, polar_angle
//   res_*        out  res_valid/stall      sigma, delta, area, ergosphere radius
//   cfg_*        in   cfg_wen              register index and write data
//
// One point per cycle while the pipe advances. The path runs through the CORDIC cell row,
// eight arithmetic stages and the 24-cell square-root row, then the result register.
// The whole pipe advances together; it holds only while a result sits unaccepted
// in the result register under res_stall. Reset empties the pipe; mass resets to 1.0,
// spin to 0.
`default_nettype none
module kerr_metric_function_eval #(
	parameter int FRAC_BITS     = 16,
	parameter int CORDIC_STAGES = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          item_valid,
	output logic                               item_stall,
	input  wire kmf_pkg::item_t                item_data,
	output logic                               res_valid,
	input  wire logic                          res_stall,
	output kmf_pkg::result_t                   res_data,
	input  wire logic                          cfg_wen,
	input  wire logic [0:0]                    cfg_index,
	input  wire logic [kmf_pkg::CFG_W-1:0]     cfg_wdata
);

	localparam logic [kmf_pkg::MASS_W-1:0] MASS_ONE = 24'(1 << FRAC_BITS);
	localparam logic [50:0]  S_HALF   = 51'(1) << (FRAC_BITS - 1);
	localparam logic signed [51:0] D_HALF = 52'sd1 <<< (FRAC_BITS - 1);
	localparam logic signed [51:0] D_MAX  = 52'sh7FFF_FFFF_FFFF;
	localparam logic signed [51:0] D_MIN  = -52'sh8000_0000_0000;
	localparam logic [101:0] A_HALF   = 102'(1) << (3 * FRAC_BITS - 1);
	localparam logic [101:0] A_MAX    = 102'(60'hFFF_FFFF_FFFF_FFFF);
	localparam logic [50:0]  S_MAX    = 51'(48'hFFFF_FFFF_FFFF);

	// configuration
	logic [kmf_pkg::MASS_W-1:0]        mass_q;
	logic signed [kmf_pkg::SPIN_W-1:0] spin_q;
	logic [48:0]                       a2_q;
	logic [47:0]                       m2_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mass_q <= MASS_ONE;
			spin_q <= '0;
		end else if (cfg_wen) begin
			case (cfg_index)
				kmf_pkg::REG_MASS: mass_q <= cfg_wdata[kmf_pkg::MASS_W-1:0];
				kmf_pkg::REG_SPIN: spin_q <= signed'(cfg_wdata);
				default: ;
			endcase
		end
	end

	logic signed [49:0] spin_sq;
	assign spin_sq = 50'(spin_q) * 50'(spin_q);

	always_ff @(posedge clk) begin
		a2_q <= spin_sq[48:0];
		m2_q <= 48'(mass_q) * 48'(mass_q);
	end

	// global advance
	logic adv;
	assign adv = !res_valid || !res_stall;
	assign item_stall = !adv;

	// angle fold into [0, pi/2]
	logic [30:0] theta;
	logic [30:0] phi;
	assign theta = {item_data.polar_angle, 15'b0};
	assign phi = (theta > 31'h4000_0000) ? 31'(32'h8000_0000 - 32'(theta)) : theta;

	kmf_pkg::cordic_t cor_pl [0:CORDIC_STAGES];
	logic             cor_v  [0:CORDIC_STAGES];

	assign cor_v[0] = item_valid;
	assign cor_pl[0].x = kmf_pkg::CORDIC_X0;
	assign cor_pl[0].y = '0;
	assign cor_pl[0].z = signed'({1'b0, phi});
	assign cor_pl[0].radius = item_data.radius;

	for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
		kmf_cordic_cell #(.STAGE(g)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (adv),
			.in_vld  (cor_v[g]),
			.in_pl   (cor_pl[g]),
			.out_vld (cor_v[g+1]),
			.out_pl  (cor_pl[g+1])
		);
	end

	kmf_pkg::cordic_t cend;
	assign cend = cor_pl[CORDIC_STAGES];

	// stage 1: squares and radius products
	logic [32:0] ax, ay;
	logic [65:0] xsq_s1, ysq_s1;
	logic [47:0] r2_s1, mr_s1;
	logic        v_s1;

	assign ax = cend.x[kmf_pkg::XY_W-1] ? 33'(-cend.x) : 33'(cend.x);
	assign ay = cend.y[kmf_pkg::XY_W-1] ? 33'(-cend.y) : 33'(cend.y);

	always_ff @(posedge clk) begin
		if (adv) begin
			xsq_s1 <= 66'(ax) * 66'(ax);
			ysq_s1 <= 66'(ay) * 66'(ay);
			r2_s1  <= 48'(cend.radius) * 48'(cend.radius);
			mr_s1  <= 48'(mass_q) * 48'(cend.radius);
		end
	end

	// stage 2: round cos^2 and sin^2, form Delta and r^2 + a^2
	logic [35:0] cq, sq;
	logic [30:0] c2_s2, s2_s2;
	logic [47:0] r2_s2;
	logic signed [50:0] d2_s2;
	logic [49:0] ssum_s2;
	logic        v_s2;

	assign cq = 36'((xsq_s1 + 66'(2**29)) >> 30);
	assign sq = 36'((ysq_s1 + 66'(2**29)) >> 30);

	always_ff @(posedge clk) begin
		if (adv) begin
			c2_s2   <= (cq > 36'(2**30)) ? 31'(2**30) : cq[30:0];
			s2_s2   <= (sq > 36'(2**30)) ? 31'(2**30) : sq[30:0];
			r2_s2   <= r2_s1;
			d2_s2   <= signed'({3'b0, r2_s1}) - signed'({2'b0, mr_s1, 1'b0})
				+ signed'({2'b0, a2_q});
			ssum_s2 <= 50'(r2_s1) + 50'(a2_q);
		end
	end

	// stage 3: partial products
	logic [54:0] pach_s3, puh_s3;
	logic [55:0] pacl_s3, pul_s3;
	logic [49:0] sll_s3, slh_s3, shh_s3;
	logic [47:0] r2_s3;
	logic signed [50:0] d2_s3;
	logic [49:0] dmag_s3;
	logic        dneg_s3;
	logic        v_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			pach_s3 <= 55'(a2_q[48:25]) * 55'(c2_s2);
			pacl_s3 <= 56'(a2_q[24:0]) * 56'(c2_s2);
			puh_s3  <= 55'(a2_q[48:25]) * 55'(s2_s2);
			pul_s3  <= 56'(a2_q[24:0]) * 56'(s2_s2);
			sll_s3  <= 50'(ssum_s2[24:0]) * 50'(ssum_s2[24:0]);
			slh_s3  <= 50'(ssum_s2[24:0]) * 50'(ssum_s2[49:25]);
			shh_s3  <= 50'(ssum_s2[49:25]) * 50'(ssum_s2[49:25]);
			r2_s3   <= r2_s2;
			d2_s3   <= d2_s2;
			dmag_s3 <= d2_s2[50] ? 50'(-d2_s2) : 50'(d2_s2);
			dneg_s3 <= d2_s2[50];
		end
	end

	// stage 4: combine a^2 cos^2, a^2 sin^2 and (r^2 + a^2)^2
	logic [79:0] acf, uf;
	logic [49:0] ac_s4, u_s4, dmag_s4;
	logic [99:0] t1_s4;
	logic [47:0] r2_s4;
	logic signed [50:0] d2_s4;
	logic        dneg_s4;
	logic        v_s4;

	assign acf = {pach_s3, 25'b0} + 80'(pacl_s3) + 80'(2**29);
	assign uf  = {puh_s3, 25'b0} + 80'(pul_s3) + 80'(2**29);

	always_ff @(posedge clk) begin
		if (adv) begin
			ac_s4   <= acf[79:30];
			u_s4    <= uf[79:30];
			t1_s4   <= (100'(shh_s3) << 50) + (100'(slh_s3) << 26) + 100'(sll_s3);
			r2_s4   <= r2_s3;
			d2_s4   <= d2_s3;
			dmag_s4 <= dmag_s3;
			dneg_s4 <= dneg_s3;
		end
	end

	// stage 5: Sigma, Delta, ergosphere radicand, partials of a^2 sin^2 Delta
	logic [50:0] sfull;
	logic signed [51:0] dsh;
	logic [47:0] sig_s5, dl_s5, diff_s5;
	logic [49:0] phh_s5, phl_s5, plh_s5, pll_s5;
	logic [99:0] t1_s5;
	logic        dneg_s5;
	logic        v_s5;

	assign sfull = (51'(r2_s4) + 51'(ac_s4) + S_HALF) >> FRAC_BITS;
	assign dsh = (52'(d2_s4) + D_HALF) >>> FRAC_BITS;

	always_ff @(posedge clk) begin
		if (adv) begin
			sig_s5 <= (sfull > S_MAX) ? 48'hFFFF_FFFF_FFFF : sfull[47:0];
			if (dsh > D_MAX) begin
				dl_s5 <= D_MAX[47:0];
			end else if (dsh < D_MIN) begin
				dl_s5 <= D_MIN[47:0];
			end else begin
				dl_s5 <= dsh[47:0];
			end
			diff_s5 <= (50'(m2_q) > ac_s4) ? 48'(50'(m2_q) - ac_s4) : '0;
			phh_s5  <= 50'(u_s4[49:25]) * 50'(dmag_s4[49:25]);
			phl_s5  <= 50'(u_s4[49:25]) * 50'(dmag_s4[24:0]);
			plh_s5  <= 50'(u_s4[24:0]) * 50'(dmag_s4[49:25]);
			pll_s5  <= 50'(u_s4[24:0]) * 50'(dmag_s4[24:0]);
			t1_s5   <= t1_s4;
			dneg_s5 <= dneg_s4;
		end
	end

	// stage 6: a^2 sin^2 |Delta|
	logic [99:0] t1_s6, t2_s6;
	logic [47:0] sig_s6, dl_s6, diff_s6;
	logic        dneg_s6;
	logic        v_s6;

	always_ff @(posedge clk) begin
		if (adv) begin
			t2_s6   <= (100'(phh_s5) << 50) + ((100'(phl_s5) + 100'(plh_s5)) << 25)
				+ 100'(pll_s5);
			t1_s6   <= t1_s5;
			sig_s6  <= sig_s5;
			dl_s6   <= dl_s5;
			diff_s6 <= diff_s5;
			dneg_s6 <= dneg_s5;
		end
	end

	// stage 7: A at full precision
	logic [101:0] aw_s7;
	logic [47:0]  sig_s7, dl_s7, diff_s7;
	logic         v_s7;

	always_ff @(posedge clk) begin
		if (adv) begin
			aw_s7   <= dneg_s6 ? (102'(t1_s6) + 102'(t2_s6)) : (102'(t1_s6) - 102'(t2_s6));
			sig_s7  <= sig_s6;
			dl_s7   <= dl_s6;
			diff_s7 <= diff_s6;
		end
	end

	// stage 8: round and clamp A
	logic [101:0] ash;
	logic [59:0]  area_s8;
	logic [47:0]  sig_s8, dl_s8, diff_s8;
	logic         v_s8;

	assign ash = (aw_s7 + A_HALF) >> (3 * FRAC_BITS);

	always_ff @(posedge clk) begin
		if (adv) begin
			if (aw_s7[101]) begin
				area_s8 <= '0;
			end else if (ash > A_MAX) begin
				area_s8 <= A_MAX[59:0];
			end else begin
				area_s8 <= ash[59:0];
			end
			sig_s8  <= sig_s7;
			dl_s8   <= dl_s7;
			diff_s8 <= diff_s7;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (adv) begin
			v_s1 <= cor_v[CORDIC_STAGES];
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	// square-root cell row
	kmf_pkg::sqrt_t sq_pl [0:kmf_pkg::SQRT_STEPS];
	logic           sq_v  [0:kmf_pkg::SQRT_STEPS];

	assign sq_v[0] = v_s8;
	assign sq_pl[0].rest  = diff_s8;
	assign sq_pl[0].rem   = '0;
	assign sq_pl[0].root  = '0;
	assign sq_pl[0].sigma = sig_s8;
	assign sq_pl[0].delta = dl_s8;
	assign sq_pl[0].area  = area_s8;

	for (genvar k = 0; k < kmf_pkg::SQRT_STEPS; k++) begin : g_sqrt
		kmf_sqrt_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (adv),
			.in_vld  (sq_v[k]),
			.in_pl   (sq_pl[k]),
			.out_vld (sq_v[k+1]),
			.out_pl  (sq_pl[k+1])
		);
	end

	// result register
	kmf_pkg::sqrt_t send;
	assign send = sq_pl[kmf_pkg::SQRT_STEPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (adv) begin
			res_valid <= sq_v[kmf_pkg::SQRT_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_data.sigma_value       <= send.sigma;
			res_data.delta_value       <= signed'(send.delta);
			res_data.area_value        <= send.area;
			res_data.ergosphere_radius <= 32'(25'(mass_q) + 25'(send.root));
		end
	end

endmodule
`default_nettype wire
